// ===== rtl/core/light_sensor_window_statistics_top_defines.svh =====
// Assertion macros for the light sensor window statistics RTL.
// No dependencies; included by the files that carry assertions.
`ifndef LIGHT_SENSOR_WINDOW_STATISTICS_TOP_DEFINES_SVH
`define LIGHT_SENSOR_WINDOW_STATISTICS_TOP_DEFINES_SVH
`ifndef SYNTH
`define LSWIN_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define LSWIN_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define LSWIN_ASSERT(lbl, prop, msg)
`define LSWIN_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/core/lswin_pkg.sv =====
// Shared constants, tables and types of the light sensor window statistics block.
// No dependencies.
package lswin_pkg;

    localparam int WINDOW = 200;
    localparam int IDX_W  = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);

    localparam int LUX_W     = 15;
    localparam int SUM_W     = 23;
    localparam int DIV_NUM_W = 40;
    localparam int DIV_DEN_W = 26;
    localparam int DIV_Q_W   = 15;

    localparam logic [9:0]       FULL_SCALE = 10'd1023;
    localparam logic [LUX_W-1:0] PCT_SCALE  = 15'd25600;
    localparam logic [3:0]       TAB_LAST   = 4'd8;

    typedef enum logic [0:0] {
        CFG_SENSE_CHANNEL = 1'b0,
        CFG_FIXED_OHMS    = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [9:0] sample;
    } t_smp;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] dividend;
        logic [DIV_DEN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DIV_Q_W-1:0] quot;
    } t_div_rsp;

    // resistance breakpoints in ohms, falling
    function automatic logic [16:0] res_at(input logic [3:0] idx);
        logic [16:0] r;
        case (idx)
            4'd0:    r = 17'd92000;
            4'd1:    r = 17'd41000;
            4'd2:    r = 17'd24000;
            4'd3:    r = 17'd16000;
            4'd4:    r = 17'd10000;
            4'd5:    r = 17'd7000;
            4'd6:    r = 17'd5000;
            4'd7:    r = 17'd1000;
            default: r = 17'd500;
        endcase
        return r;
    endfunction

    // lux in Q7.8 at each breakpoint
    function automatic logic [LUX_W-1:0] lux_at(input logic [3:0] idx);
        logic [LUX_W-1:0] l;
        case (idx)
            4'd0:    l = 15'd128;
            4'd1:    l = 15'd256;
            4'd2:    l = 15'd768;
            4'd3:    l = 15'd1536;
            4'd4:    l = 15'd2560;
            4'd5:    l = 15'd3840;
            4'd6:    l = 15'd8960;
            4'd7:    l = 15'd20480;
            default: l = 15'd25600;
        endcase
        return l;
    endfunction

endpackage

// ===== rtl/core/lswin_front.sv =====
// Front end: accepts samples, drops other channels, queues the rest (two deep).
// Depends on lswin_pkg.
module lswin_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [3:0]        i_channel,
    input  logic [9:0]        i_adc_sample,
    input  logic [3:0]        i_sense_channel,
    output logic              o_q_vld,
    output lswin_pkg::t_smp   o_q_data,
    input  logic              i_q_pop
);

    lswin_pkg::t_smp r_buf [0:1];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    logic            w_push;
    logic            w_pop;

    assign o_stall  = (r_cnt == 2'd2);
    assign w_push   = i_valid && !o_stall && (i_channel == i_sense_channel);
    assign w_pop    = i_q_pop && (r_cnt != 2'd0);
    assign o_q_vld  = (r_cnt != 2'd0);
    assign o_q_data = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wp].sample <= i_adc_sample;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

// ===== rtl/core/lswin_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// Depends on lswin_pkg.
module lswin_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lswin_pkg::t_div_req  i_req,
    output lswin_pkg::t_div_rsp  o_rsp
);

    logic [lswin_pkg::DIV_NUM_W-1:0] r_rem;
    logic [lswin_pkg::DIV_NUM_W-1:0] r_dsh;
    logic [lswin_pkg::DIV_Q_W-1:0]   r_q;
    logic [3:0]                      r_cnt;
    logic                            r_busy;
    logic                            r_done;
    logic                            w_ge;

    assign w_ge        = (r_rem >= r_dsh);
    assign o_rsp.done  = r_done;
    assign o_rsp.quot  = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && !i_req.start && (r_cnt == 4'd0);
            if (i_req.start) begin
                r_rem  <= i_req.dividend;
                r_dsh  <= lswin_pkg::DIV_NUM_W'({i_req.divisor, 14'd0});
                r_cnt  <= 4'(lswin_pkg::DIV_Q_W - 1);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (w_ge) r_rem <= r_rem - r_dsh;
                r_q   <= {r_q[lswin_pkg::DIV_Q_W-2:0], w_ge};
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

endmodule

// ===== rtl/core/lswin_back.sv =====
// Back end: lux conversion sequencer, lux ring with running sum, window scan,
// mean and range division, output register. Depends on lswin_pkg and lswin_div.
`include "light_sensor_window_statistics_top_defines.svh"
module lswin_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_vld,
    input  lswin_pkg::t_smp              i_q_data,
    output logic                         o_q_pop,
    input  logic [15:0]                  i_fixed_ohms,
    output lswin_pkg::t_div_req          o_div_req,
    input  lswin_pkg::t_div_rsp          i_div_rsp,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [lswin_pkg::LUX_W-1:0]  o_lux_now,
    output logic [lswin_pkg::LUX_W-1:0]  o_lux_min,
    output logic [lswin_pkg::LUX_W-1:0]  o_lux_max,
    output logic [lswin_pkg::LUX_W-1:0]  o_lux_mean,
    output logic [lswin_pkg::LUX_W-1:0]  o_range_percent
);

    typedef enum logic [4:0] {
        B_IDLE, B_NUM, B_EDGE0, B_EDGE8, B_SRCH, B_DIFF, B_PROD, B_LWAIT,
        B_RDOLD, B_UPD, B_SCAN, B_MEAN, B_MWAIT, B_PCT, B_PWAIT, B_OUT
    } t_state;

    localparam int LW = lswin_pkg::LUX_W;
    localparam int IW = lswin_pkg::IDX_W;
    localparam int CW = lswin_pkg::CNT_W;

    t_state                        r_state;
    logic [9:0]                    r_s;
    logic [25:0]                   r_num;
    logic [3:0]                    r_j;
    logic [3:0]                    r_seg;
    logic [25:0]                   r_diff;
    logic [25:0]                   r_den;
    logic [LW-1:0]                 r_lux;
    logic [IW-1:0]                 r_slot;
    logic [CW-1:0]                 r_filled;
    logic [lswin_pkg::SUM_W-1:0]   r_sum;
    logic [CW-1:0]                 r_k;
    logic                          r_pend;
    logic                          r_first;
    logic [LW-1:0]                 r_lo;
    logic [LW-1:0]                 r_hi;
    logic [LW-1:0]                 r_mean;
    logic [LW-1:0]                 r_pct;
    lswin_pkg::t_div_req           r_req;
    logic                          r_out_vld;
    logic [LW-1:0]                 r_o_lux;
    logic [LW-1:0]                 r_o_lo;
    logic [LW-1:0]                 r_o_hi;
    logic [LW-1:0]                 r_o_mean;
    logic [LW-1:0]                 r_o_pct;

    logic [LW-1:0]                 r_ring [0:lswin_pkg::WINDOW-1];
    logic [LW-1:0]                 r_rdata;

    logic [3:0]                    w_midx;
    logic [26:0]                   w_mprod;
    logic [16:0]                   w_dres;
    logic [LW-1:0]                 w_dlux;
    logic                          w_full;
    logic                          w_we;
    logic [IW-1:0]                 w_raddr;

    always_comb begin
        case (r_state)
            B_EDGE0: w_midx = 4'd0;
            B_EDGE8: w_midx = lswin_pkg::TAB_LAST;
            B_SRCH:  w_midx = r_j;
            B_DIFF:  w_midx = r_seg;
            default: w_midx = 4'd0;
        endcase
    end

    assign w_mprod = 27'(lswin_pkg::res_at(w_midx)) * 27'(r_s);
    assign w_dres  = lswin_pkg::res_at(r_seg) - lswin_pkg::res_at(r_seg + 4'd1);
    assign w_dlux  = lswin_pkg::lux_at(r_seg + 4'd1) - lswin_pkg::lux_at(r_seg);
    assign w_full  = (r_filled == CW'(lswin_pkg::WINDOW));
    assign w_we    = (r_state == B_UPD);
    assign w_raddr = (r_state == B_SCAN) ? r_k[IW-1:0] : r_slot;

    assign o_q_pop         = (r_state == B_IDLE) && i_q_vld;
    assign o_div_req       = r_req;
    assign o_valid         = r_out_vld;
    assign o_lux_now       = r_o_lux;
    assign o_lux_min       = r_o_lo;
    assign o_lux_max       = r_o_hi;
    assign o_lux_mean      = r_o_mean;
    assign o_range_percent = r_o_pct;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_ring[r_slot] <= r_lux;
        end
        r_rdata <= r_ring[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_req.start <= 1'b0;
            r_out_vld   <= 1'b0;
            r_slot      <= '0;
            r_filled    <= '0;
            r_sum       <= '0;
        end else begin
            // launch a division from the three request states, from B_PCT only if max exceeds min
            r_req.start <= (r_state == B_PROD) || (r_state == B_MEAN)
                           || (r_state == B_PCT && r_hi > r_lo);
            if (r_state == B_OUT && (!r_out_vld || !i_stall)) r_out_vld <= 1'b1;
            else if (r_out_vld && !i_stall) r_out_vld <= 1'b0;
            case (r_state)
                B_IDLE: begin
                    if (i_q_vld) begin
                        r_s     <= i_q_data.sample;
                        r_state <= B_NUM;
                    end
                end
                B_NUM: begin
                    // zero sample means infinite resistance
                    if (r_s == 10'd0) begin
                        r_lux   <= lswin_pkg::lux_at(4'd0);
                        r_state <= B_RDOLD;
                    end else begin
                        r_num   <= 26'(i_fixed_ohms * (lswin_pkg::FULL_SCALE - r_s));
                        r_state <= B_EDGE0;
                    end
                end
                B_EDGE0: begin
                    if (27'(r_num) >= w_mprod) begin
                        r_lux   <= lswin_pkg::lux_at(4'd0);
                        r_state <= B_RDOLD;
                    end else begin
                        r_state <= B_EDGE8;
                    end
                end
                B_EDGE8: begin
                    if (27'(r_num) <= w_mprod) begin
                        r_lux   <= lswin_pkg::lux_at(lswin_pkg::TAB_LAST);
                        r_state <= B_RDOLD;
                    end else begin
                        r_j     <= 4'd1;
                        r_state <= B_SRCH;
                    end
                end
                B_SRCH: begin
                    // the last breakpoint always hits here
                    if (27'(r_num) >= w_mprod) begin
                        r_seg   <= r_j - 4'd1;
                        r_state <= B_DIFF;
                    end else begin
                        r_j <= r_j + 4'd1;
                    end
                end
                B_DIFF: begin
                    r_diff  <= 26'(w_mprod - 27'(r_num));
                    r_den   <= 26'(w_dres * 17'(r_s));
                    r_state <= B_PROD;
                end
                B_PROD: begin
                    r_req.dividend <= 40'(r_diff) * 40'(w_dlux);
                    r_req.divisor  <= r_den;
                    r_state        <= B_LWAIT;
                end
                B_LWAIT: begin
                    if (i_div_rsp.done) begin
                        r_lux   <= lswin_pkg::lux_at(r_seg) + i_div_rsp.quot;
                        r_state <= B_RDOLD;
                    end
                end
                B_RDOLD: begin
                    // outgoing entry is read at the write slot
                    r_state <= B_UPD;
                end
                B_UPD: begin
                    r_sum <= r_sum - (w_full ? lswin_pkg::SUM_W'(r_rdata) : '0)
                             + lswin_pkg::SUM_W'(r_lux);
                    if (!w_full) r_filled <= r_filled + CW'(1);
                    if (r_slot == IW'(lswin_pkg::WINDOW - 1)) r_slot <= '0;
                    else r_slot <= r_slot + IW'(1);
                    r_k     <= '0;
                    r_pend  <= 1'b0;
                    r_first <= 1'b1;
                    r_state <= B_SCAN;
                end
                B_SCAN: begin
                    if (r_k != r_filled) begin
                        r_k    <= r_k + CW'(1);
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                    end
                    if (r_pend) begin
                        r_first <= 1'b0;
                        if (r_first || r_rdata < r_lo) r_lo <= r_rdata;
                        if (r_first || r_rdata > r_hi) r_hi <= r_rdata;
                    end
                    if (r_k == r_filled && !r_pend) r_state <= B_MEAN;
                end
                B_MEAN: begin
                    r_req.dividend <= lswin_pkg::DIV_NUM_W'(r_sum);
                    r_req.divisor  <= lswin_pkg::DIV_DEN_W'(r_filled);
                    r_state        <= B_MWAIT;
                end
                B_MWAIT: begin
                    if (i_div_rsp.done) begin
                        r_mean  <= i_div_rsp.quot;
                        r_state <= B_PCT;
                    end
                end
                B_PCT: begin
                    if (r_hi > r_lo) begin
                        r_req.dividend <= 40'(r_lux - r_lo) * 40'(lswin_pkg::PCT_SCALE);
                        r_req.divisor  <= lswin_pkg::DIV_DEN_W'(r_hi - r_lo);
                        r_state        <= B_PWAIT;
                    end else begin
                        r_pct   <= '0;
                        r_state <= B_OUT;
                    end
                end
                B_PWAIT: begin
                    if (i_div_rsp.done) begin
                        r_pct   <= i_div_rsp.quot;
                        r_state <= B_OUT;
                    end
                end
                B_OUT: begin
                    if (!r_out_vld || !i_stall) begin
                        r_o_lux   <= r_lux;
                        r_o_lo    <= r_lo;
                        r_o_hi    <= r_hi;
                        r_o_mean  <= r_mean;
                        r_o_pct   <= r_pct;
                        r_state   <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    `LSWIN_ASSERT(a_filled_bound, r_filled <= CW'(lswin_pkg::WINDOW), "fill count beyond window")
    `LSWIN_ASSERT(a_slot_bound, r_slot < IW'(lswin_pkg::WINDOW), "write slot beyond window")
    `LSWIN_ASSERT(a_scan_bound, (r_state == B_SCAN) |-> (r_k <= r_filled), "scan past fill")
    `LSWIN_ASSERT(a_div_done, i_div_rsp.done |-> (r_state == B_LWAIT || r_state == B_MWAIT || r_state == B_PWAIT), "divider done outside wait")

endmodule

// ===== rtl/core/light_sensor_window_statistics_top.sv =====
// Light sensor window statistics: the back end takes the next sample only when it is
// through with the last. Its work per sample is set by the min/max scan through the
// ring's single read port, one entry per cycle over the filled part of the 200-entry
// window, and by up to three passes of the shared 15-step divider. Samples of other
// channels are dropped at acceptance. The front queue holds two samples, the output
// register one result.
// Top level: configuration registers and wiring. Depends on lswin_pkg,
// lswin_front, lswin_div, lswin_back.
module light_sensor_window_statistics_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_channel,
    input  logic [9:0]  i_adc_sample,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [14:0] o_lux_now,
    output logic [14:0] o_lux_min,
    output logic [14:0] o_lux_max,
    output logic [14:0] o_lux_mean,
    output logic [14:0] o_range_percent,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    logic [3:0]           r_sense_channel;
    logic [15:0]          r_fixed_ohms;
    logic                 w_q_vld;
    lswin_pkg::t_smp      w_q_data;
    logic                 w_q_pop;
    lswin_pkg::t_div_req  w_div_req;
    lswin_pkg::t_div_rsp  w_div_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sense_channel <= 4'd1;
            r_fixed_ohms    <= 16'd1000;
        end else if (i_cfg_we) begin
            case (lswin_pkg::t_cfg_idx'(i_cfg_idx))
                lswin_pkg::CFG_SENSE_CHANNEL: r_sense_channel <= i_cfg_data[3:0];
                lswin_pkg::CFG_FIXED_OHMS:    r_fixed_ohms    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lswin_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_channel       (i_channel),
        .i_adc_sample    (i_adc_sample),
        .i_sense_channel (r_sense_channel),
        .o_q_vld         (w_q_vld),
        .o_q_data        (w_q_data),
        .i_q_pop         (w_q_pop)
    );

    lswin_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    lswin_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_vld         (w_q_vld),
        .i_q_data        (w_q_data),
        .o_q_pop         (w_q_pop),
        .i_fixed_ohms    (r_fixed_ohms),
        .o_div_req       (w_div_req),
        .i_div_rsp       (w_div_rsp),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_lux_now       (o_lux_now),
        .o_lux_min       (o_lux_min),
        .o_lux_max       (o_lux_max),
        .o_lux_mean      (o_lux_mean),
        .o_range_percent (o_range_percent)
    );

endmodule

// ===== tb/light_sensor_window_statistics_top_tb.sv =====
// Testbench for light_sensor_window_statistics_top: drives converter samples with
// random bursts and output stalls, predicts lux and window statistics, checks them.
// Depends on lswin_pkg and the RTL of the block.
module light_sensor_window_statistics_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN   = lswin_pkg::WINDOW;
    localparam int DRAIN = 600;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [3:0]  i_channel;
    logic [9:0]  i_adc_sample;
    logic        o_valid;
    logic        i_stall;
    logic [14:0] o_lux_now;
    logic [14:0] o_lux_min;
    logic [14:0] o_lux_max;
    logic [14:0] o_lux_mean;
    logic [14:0] o_range_percent;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    typedef struct packed {
        logic [14:0] now;
        logic [14:0] lo;
        logic [14:0] hi;
        logic [14:0] mean;
        logic [14:0] pct;
    } t_stats;

    // predictor state
    logic [3:0]  pred_channel;
    logic [15:0] pred_ohms;
    logic [14:0] lux_hist [WIN];
    int          hist_slot;
    int          hist_count;
    longint      hist_sum;

    t_stats stats_q[$];
    int     mismatches;
    int     hold_cycles;
    bit     stall_mode;

    light_sensor_window_statistics_top i_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic longint res_pt(int i);
        longint r[9] = '{92000, 41000, 24000, 16000, 10000, 7000, 5000, 1000, 500};
        return r[i];
    endfunction

    function automatic longint lux_pt(int i);
        longint l[9] = '{128, 256, 768, 1536, 2560, 3840, 8960, 20480, 25600};
        return l[i];
    endfunction

    function automatic longint sample_lux(logic [9:0] s);
        longint num;
        longint sv;
        sv = s;
        if (sv == 0) return lux_pt(0);
        num = longint'(pred_ohms) * (1023 - sv);
        if (num >= res_pt(0) * sv) return lux_pt(0);
        if (num <= res_pt(8) * sv) return lux_pt(8);
        for (int i = 0; i < 8; i++) begin
            if (num >= res_pt(i + 1) * sv)
                return lux_pt(i) + (res_pt(i) * sv - num) * (lux_pt(i + 1) - lux_pt(i))
                       / ((res_pt(i) - res_pt(i + 1)) * sv);
        end
        return lux_pt(8);
    endfunction

    task automatic predict_stats(logic [3:0] ch, logic [9:0] s);
        longint lux;
        longint lo;
        longint hi;
        t_stats e;
        if (ch != pred_channel) return;
        lux = sample_lux(s);
        if (hist_count >= WIN) hist_sum -= lux_hist[hist_slot];
        else hist_count++;
        lux_hist[hist_slot] = lux[14:0];
        hist_sum += lux;
        hist_slot = (hist_slot + 1) % WIN;
        lo = lux_hist[0];
        hi = lux_hist[0];
        for (int k = 1; k < hist_count; k++) begin
            if (lux_hist[k] < lo) lo = lux_hist[k];
            if (lux_hist[k] > hi) hi = lux_hist[k];
        end
        e.now  = lux[14:0];
        e.lo   = lo[14:0];
        e.hi   = hi[14:0];
        e.mean = 15'(hist_sum / hist_count);
        e.pct  = (hi > lo && lux >= lo) ? 15'((lux - lo) * 25600 / (hi - lo)) : 15'd0;
        stats_q.push_back(e);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // check each result transaction against the oldest prediction
    always @(posedge i_clk) begin
        t_stats e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (stats_q.size() == 0) begin
                report_mismatch("unexpected result", o_lux_now, -1);
            end else begin
                e = stats_q.pop_front();
                if (o_lux_now != e.now) report_mismatch("lux_now", o_lux_now, e.now);
                if (o_lux_min != e.lo) report_mismatch("lux_min", o_lux_min, e.lo);
                if (o_lux_max != e.hi) report_mismatch("lux_max", o_lux_max, e.hi);
                if (o_lux_mean != e.mean) report_mismatch("lux_mean", o_lux_mean, e.mean);
                if (o_range_percent != e.pct)
                    report_mismatch("range_percent", o_range_percent, e.pct);
            end
        end
    end

    // output stall pattern, with an optional long hold-off
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1'b1;
        end else if (stall_mode) begin
            i_stall <= ($urandom_range(0, 3) == 0);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // valid stays high after acceptance; a gap before a paced send or an idle period drops it
    task automatic send_sample(logic [3:0] ch, logic [9:0] s);
        i_valid      <= 1'b1;
        i_channel    <= ch;
        i_adc_sample <= s;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_stats(ch, s);
    endtask

    // occasional gaps between bursts
    task automatic send_paced(logic [3:0] ch, logic [9:0] s);
        if ($urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        send_sample(ch, s);
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        i_valid <= 1'b0;
        while (stats_q.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_reg(lswin_pkg::t_cfg_idx idx, logic [15:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == lswin_pkg::CFG_SENSE_CHANNEL) pred_channel = value[3:0];
        else pred_ohms = value;
        @(posedge i_clk);
    endtask

    task automatic test_directed();
        logic [9:0] s_list[12] = '{0, 1, 1023, 512, 8, 20, 100, 200, 341, 700, 900, 1000};
        foreach (s_list[i]) send_sample(4'd1, s_list[i]);
        send_sample(4'd0, 10'd300);
        send_sample(4'd15, 10'd300);
        send_sample(4'd1, 10'd512);
        send_sample(4'd1, 10'd512);
        wait_idle();
    endtask

    task automatic test_config_extremes();
        write_reg(lswin_pkg::CFG_FIXED_OHMS, 16'd1);
        write_reg(lswin_pkg::CFG_SENSE_CHANNEL, 4'd15);
        send_sample(4'd15, 10'd1);
        send_sample(4'd15, 10'd1023);
        send_sample(4'd1, 10'd50);
        wait_idle();
        write_reg(lswin_pkg::CFG_FIXED_OHMS, 16'd65535);
        send_sample(4'd15, 10'd1022);
        send_sample(4'd15, 10'd700);
        send_sample(4'd15, 10'd0);
        wait_idle();
        write_reg(lswin_pkg::CFG_SENSE_CHANNEL, 4'd0);
        send_sample(4'd0, 10'd990);
        wait_idle();
    endtask

    // fill and wrap the window under random output stalls
    task automatic test_random(int n, logic [15:0] ohms, logic [3:0] ch);
        write_reg(lswin_pkg::CFG_FIXED_OHMS, ohms);
        write_reg(lswin_pkg::CFG_SENSE_CHANNEL, ch);
        stall_mode = 1'b1;
        for (int i = 0; i < n; i++)
            send_paced(($urandom_range(0, 9) == 0) ? 4'($urandom) : ch, 10'($urandom));
        wait_idle();
        stall_mode = 1'b0;
    endtask

    // hold off the output while samples keep coming, so the input stalls
    task automatic test_backpressure();
        write_reg(lswin_pkg::CFG_FIXED_OHMS, 16'd1000);
        write_reg(lswin_pkg::CFG_SENSE_CHANNEL, 4'd1);
        hold_cycles = 2000;
        for (int i = 0; i < 12; i++) send_sample(4'd1, 10'($urandom));
        wait_idle();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_channel = '0;
        i_adc_sample = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = lswin_pkg::CFG_SENSE_CHANNEL;
        i_cfg_data = '0;
        hold_cycles = 0;
        stall_mode = 1'b0;
        mismatches = 0;
        pred_channel = 4'd1;
        pred_ohms = 16'd1000;
        hist_slot = 0;
        hist_count = 0;
        hist_sum = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_config_extremes();
        test_random(450, 16'd1000, 4'd1);
        test_backpressure();
        test_random(300, 16'd10000, 4'd7);
        test_random(250, 16'($urandom_range(1, 65535)), 4'($urandom));
        if (stats_q.size() != 0) report_mismatch("results left over", stats_q.size(), 0);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
